[src/pst_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Padded string table package
// Shared types, codes and helper functions for the string table and its cells.
// ----------------------------------------------------------------------------
package pst_pkg;

    localparam int MAX_ENTRIES_DEF      = 256;
    localparam int MAX_STRING_BYTES_DEF = 64;
    localparam int CHUNK_BITS           = 64;
    localparam int SLOT_BITS_MAX        = 512;

    localparam logic [2:0] OP_GET    = 3'd0;
    localparam logic [2:0] OP_SET    = 3'd1;
    localparam logic [2:0] OP_INSERT = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_FIND   = 3'd4;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_RANGE     = 2'd3;

    typedef struct packed {
        logic [2:0]            opcode;
        logic [8:0]            position;
        logic [5:0]            length;
        logic [CHUNK_BITS-1:0] chunk0;
        logic [CHUNK_BITS-1:0] chunk1;
        logic [CHUNK_BITS-1:0] chunk2;
        logic [CHUNK_BITS-1:0] chunk3;
        logic [CHUNK_BITS-1:0] chunk4;
        logic [CHUNK_BITS-1:0] chunk5;
        logic [CHUNK_BITS-1:0] chunk6;
        logic [CHUNK_BITS-1:0] chunk7;
    } t_req;

    typedef struct packed {
        logic [CHUNK_BITS-1:0] out_chunk0;
        logic [CHUNK_BITS-1:0] out_chunk1;
        logic [CHUNK_BITS-1:0] out_chunk2;
        logic [CHUNK_BITS-1:0] out_chunk3;
        logic [CHUNK_BITS-1:0] out_chunk4;
        logic [CHUNK_BITS-1:0] out_chunk5;
        logic [CHUNK_BITS-1:0] out_chunk6;
        logic [CHUNK_BITS-1:0] out_chunk7;
        logic [7:0]            match_index;
        logic [1:0]            status;
        logic [8:0]            entry_total;
        logic [2:0]            width_class;
    } t_rsp;

    typedef struct packed {
        logic do_set;
        logic do_insert;
        logic do_delete;
        logic do_eval;
        logic eval_find;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESOLVE
    } t_state;

    function automatic logic [2:0] class_of(input logic [5:0] len);
        logic [2:0] code;
        if (len == 6'd0) begin
            code = 3'd0;
        end else if (len < 6'd4) begin
            code = 3'd1;
        end else if (len < 6'd8) begin
            code = 3'd2;
        end else if (len < 6'd16) begin
            code = 3'd3;
        end else if (len < 6'd32) begin
            code = 3'd4;
        end else begin
            code = 3'd5;
        end
        return code;
    endfunction

    function automatic logic [7:0] class_bytes(input logic [2:0] code);
        logic [7:0] bytes;
        if (code == 3'd0) begin
            bytes = 8'd0;
        end else begin
            bytes = 8'd2 << code;
        end
        return bytes;
    endfunction

endpackage
`default_nettype wire

[src/pst_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one table request.
// ----------------------------------------------------------------------------
interface pst_req_if;
    logic          valid;
    logic          ready;
    pst_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/pst_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one table response.
// ----------------------------------------------------------------------------
interface pst_rsp_if;
    logic          valid;
    logic          ready;
    pst_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/pst_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// String table cell
// Holds one padded entry, takes data from either neighbor for insert and
// delete shifts, and flags a position or value hit.
// ----------------------------------------------------------------------------
module pst_cell #(
    parameter int SLOT_BITS = 512,
    parameter int CMP_W     = 9
) (
    input  wire                     i_clk,
    input  wire pst_pkg::t_cell_ctl i_ctl,
    input  wire  [CMP_W-1:0]        i_index,
    input  wire  [CMP_W-1:0]        i_pos,
    input  wire  [CMP_W-1:0]        i_count,
    input  wire  [SLOT_BITS-1:0]    i_value,
    input  wire  [SLOT_BITS-1:0]    i_prev,
    input  wire  [SLOT_BITS-1:0]    i_next,
    output logic [SLOT_BITS-1:0]    o_data,
    output logic                    o_hit
);

    logic [SLOT_BITS-1:0] r_data;
    logic [SLOT_BITS-1:0] n_data;
    logic                 r_hit;
    logic                 n_hit;
    logic                 w_at_pos;
    logic                 w_above_pos;
    logic                 w_live;
    logic                 w_not_last;

    assign w_at_pos    = (i_index == i_pos);
    assign w_above_pos = (i_index > i_pos);
    assign w_live      = (i_index < i_count);
    assign w_not_last  = ((i_index + CMP_W'(1)) < i_count);

    always_comb begin
        n_data = r_data;
        if ((i_ctl.do_set || i_ctl.do_insert) && w_at_pos) begin
            n_data = i_value;
        end else if (i_ctl.do_insert && w_above_pos && (i_index <= i_count)) begin
            n_data = i_prev;
        end else if (i_ctl.do_delete && (w_at_pos || w_above_pos) && w_not_last) begin
            n_data = i_next;
        end
    end

    always_comb begin
        n_hit = r_hit;
        if (i_ctl.do_eval) begin
            if (i_ctl.eval_find) begin
                n_hit = w_live && (r_data == i_value);
            end else begin
                n_hit = w_at_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_hit  <= n_hit;
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule
`default_nettype wire

[src/padded_string_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Padded string table
// Ordered table of zero-padded byte strings built as a row of cells.
// ----------------------------------------------------------------------------
// A request is registered at the edge that accepts it. In the next cycle every
// cell shifts, writes or compares its own entry in parallel. In the resolve
// state after that, the first hit among all cells is selected and the response
// register is loaded. The request channel is ready again in the cycle after the
// response is loaded, so a request is accepted only when the one before it is
// done. A new request is accepted while a finished response still waits in the
// output register. The next response then holds the block in its selection
// cycle until that register is taken.
// Get, set, insert and delete at a position not below the entry count (above
// it for insert) return status 3; insert into a full table returns status 2;
// find without an equal entry returns status 1. Stored entries need no
// clearing after reset, so the table is usable in the first cycle after reset.
// ----------------------------------------------------------------------------
module padded_string_table #(
    parameter int MAX_ENTRIES      = pst_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_STRING_BYTES = pst_pkg::MAX_STRING_BYTES_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    pst_req_if.sink   i_req,
    pst_rsp_if.source o_rsp
);

    localparam int SLOT_BITS = 8 * MAX_STRING_BYTES;
    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W     = $clog2(MAX_ENTRIES);
    localparam int CMP_W     = (CNT_W > 9) ? CNT_W : 9;
    localparam int MIDX_W    = (IDX_W > 8) ? IDX_W : 8;
    localparam int LEN_MAX   = MAX_STRING_BYTES - 1;

    pst_pkg::t_state    r_state;
    pst_pkg::t_state    n_state;
    logic [2:0]         r_op;
    logic [CMP_W-1:0]   r_pos;
    logic [5:0]         r_len;
    logic [SLOT_BITS-1:0] r_value;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [2:0]         r_code;
    logic [2:0]         n_code;
    logic [1:0]         r_status;
    logic [1:0]         n_status;
    logic               r_fits;
    logic               n_fits;
    pst_pkg::t_rsp      r_rsp;
    pst_pkg::t_rsp      n_rsp;
    logic               r_rsp_valid;
    logic               n_rsp_valid;

    pst_pkg::t_cell_ctl w_ctl;
    logic               w_accept;
    logic [5:0]         w_len_sat;
    logic [pst_pkg::SLOT_BITS_MAX-1:0] w_raw;
    logic [SLOT_BITS-1:0] w_value;
    logic [CMP_W-1:0]   w_count_x;
    logic               w_pos_lt;
    logic               w_pos_le;
    logic               w_full;
    logic [2:0]         w_len_class;
    logic [7:0]         w_width_bytes;

    logic [SLOT_BITS-1:0] w_cell [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] w_hit;
    logic [MAX_ENTRIES-1:0] w_first;
    logic [MIDX_W-1:0]  w_first_idx;
    logic [SLOT_BITS-1:0] w_sel_data;
    logic [pst_pkg::SLOT_BITS_MAX-1:0] w_rd;

    assign w_accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == pst_pkg::ST_IDLE);

    assign w_len_sat = (i_req.data.length > 6'(LEN_MAX)) ? 6'(LEN_MAX) : i_req.data.length;
    assign w_raw = {i_req.data.chunk7, i_req.data.chunk6, i_req.data.chunk5,
                    i_req.data.chunk4, i_req.data.chunk3, i_req.data.chunk2,
                    i_req.data.chunk1, i_req.data.chunk0};

    always_comb begin
        for (int b = 0; b < MAX_STRING_BYTES; b++) begin
            w_value[8*b +: 8] = (7'(b) < {1'b0, w_len_sat}) ? w_raw[8*b +: 8] : 8'd0;
        end
    end

    assign w_count_x     = CMP_W'(r_count);
    assign w_pos_lt      = (r_pos < w_count_x);
    assign w_pos_le      = (r_pos <= w_count_x);
    assign w_full        = (r_count == CNT_W'(MAX_ENTRIES));
    assign w_len_class   = pst_pkg::class_of(r_len);
    assign w_width_bytes = pst_pkg::class_bytes(r_code);

    genvar k;
    generate
        for (k = 0; k < MAX_ENTRIES; k++) begin : g_cell
            pst_cell #(
                .SLOT_BITS (SLOT_BITS),
                .CMP_W     (CMP_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_index (CMP_W'(k)),
                .i_pos   (r_pos),
                .i_count (w_count_x),
                .i_value (r_value),
                .i_prev  ((k == 0) ? r_value : w_cell[(k == 0) ? 0 : k - 1]),
                .i_next  ((k == MAX_ENTRIES - 1) ? w_cell[k]
                                                 : w_cell[(k == MAX_ENTRIES - 1) ? k : k + 1]),
                .o_data  (w_cell[k]),
                .o_hit   (w_hit[k])
            );
        end
    endgenerate

    // Lowest set hit bit, isolated as a one-hot vector.
    assign w_first = w_hit & (~w_hit + MAX_ENTRIES'(1));

    always_comb begin
        w_first_idx = '0;
        w_sel_data  = '0;
        for (int e = 0; e < MAX_ENTRIES; e++) begin
            if (w_first[e]) begin
                w_first_idx = w_first_idx | MIDX_W'(e);
                w_sel_data  = w_sel_data | w_cell[e];
            end
        end
    end

    assign w_rd = pst_pkg::SLOT_BITS_MAX'(w_sel_data);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_code      = r_code;
        n_status    = r_status;
        n_fits      = r_fits;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid;
        w_ctl       = '0;

        if (o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end

        unique case (r_state)
            pst_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = pst_pkg::ST_EXEC;
                end
            end
            pst_pkg::ST_EXEC: begin
                n_status = pst_pkg::STAT_OK;
                n_fits   = 1'b0;
                if (r_op == pst_pkg::OP_GET) begin
                    w_ctl.do_eval = 1'b1;
                    if (!w_pos_lt) begin
                        n_status = pst_pkg::STAT_RANGE;
                    end
                end else if (r_op == pst_pkg::OP_SET) begin
                    if (w_pos_lt) begin
                        w_ctl.do_set = 1'b1;
                        if (w_len_class > r_code) begin
                            n_code = w_len_class;
                        end
                    end else begin
                        n_status = pst_pkg::STAT_RANGE;
                    end
                end else if (r_op == pst_pkg::OP_INSERT) begin
                    if (!w_pos_le) begin
                        n_status = pst_pkg::STAT_RANGE;
                    end else if (w_full) begin
                        n_status = pst_pkg::STAT_FULL;
                    end else begin
                        w_ctl.do_insert = 1'b1;
                        n_count = r_count + CNT_W'(1);
                        if (w_len_class > r_code) begin
                            n_code = w_len_class;
                        end
                    end
                end else if (r_op == pst_pkg::OP_DELETE) begin
                    if (w_pos_lt) begin
                        w_ctl.do_delete = 1'b1;
                        n_count = r_count - CNT_W'(1);
                    end else begin
                        n_status = pst_pkg::STAT_RANGE;
                    end
                end else if (r_op == pst_pkg::OP_FIND) begin
                    w_ctl.do_eval   = 1'b1;
                    w_ctl.eval_find = 1'b1;
                    n_fits = (r_code == 3'd0) ? (r_len == 6'd0)
                                              : ({2'b00, r_len} < w_width_bytes);
                end
                n_state = pst_pkg::ST_RESOLVE;
            end
            pst_pkg::ST_RESOLVE: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    n_rsp             = '0;
                    n_rsp.status      = r_status;
                    n_rsp.entry_total = w_count_x[8:0];
                    n_rsp.width_class = r_code;
                    if (r_op == pst_pkg::OP_GET && r_status == pst_pkg::STAT_OK) begin
                        n_rsp.out_chunk0 = w_rd[0*64 +: 64];
                        n_rsp.out_chunk1 = w_rd[1*64 +: 64];
                        n_rsp.out_chunk2 = w_rd[2*64 +: 64];
                        n_rsp.out_chunk3 = w_rd[3*64 +: 64];
                        n_rsp.out_chunk4 = w_rd[4*64 +: 64];
                        n_rsp.out_chunk5 = w_rd[5*64 +: 64];
                        n_rsp.out_chunk6 = w_rd[6*64 +: 64];
                        n_rsp.out_chunk7 = w_rd[7*64 +: 64];
                    end else if (r_op == pst_pkg::OP_FIND) begin
                        if (r_fits && (|w_hit)) begin
                            n_rsp.match_index = w_first_idx[7:0];
                        end else begin
                            n_rsp.status = pst_pkg::STAT_NOT_FOUND;
                        end
                    end
                    n_rsp_valid = 1'b1;
                    n_state     = pst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pst_pkg::ST_IDLE;
            r_count     <= '0;
            r_code      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_code      <= n_code;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_req.data.opcode;
            r_pos   <= CMP_W'(i_req.data.position);
            r_len   <= w_len_sat;
            r_value <= w_value;
        end
        r_status <= n_status;
        r_fits   <= n_fits;
        r_rsp    <= n_rsp;
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

endmodule
`default_nettype wire

[tb/sv/pst_table_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// String table response checker
// Watches the request and response channels of the padded string table. It
// keeps its own copy of the entries, the entry count and the width class,
// works out the response for every accepted request and compares each
// accepted response, field by field, with the oldest expected one.
// ----------------------------------------------------------------------------
module pst_table_checker (
    input  wire i_clk,
    input  wire i_rst_n,
    pst_req_if  i_req,
    pst_rsp_if  i_rsp,
    output int  o_errors,
    output int  o_waiting
);
    import pst_pkg::*;

    localparam int DEPTH      = MAX_ENTRIES_DEF;
    localparam int SLOT_BYTES = SLOT_BITS_MAX / 8;

    logic [SLOT_BITS_MAX-1:0] slots [DEPTH];
    int                       used;
    logic [2:0]               width_code;
    t_rsp                     expected_rsp_q[$];

    initial o_errors = 0;

    function automatic logic [2:0] width_needed(input int len);
        logic [2:0] code;
        code = 3'd0;
        if (len != 0) code = 3'd1;
        if (len >= 4) code = 3'd2;
        if (len >= 8) code = 3'd3;
        if (len >= 16) code = 3'd4;
        if (len >= 32) code = 3'd5;
        return code;
    endfunction

    function automatic int width_bytes(input logic [2:0] code);
        return (code == 3'd0) ? 0 : (1 << (code + 1));
    endfunction

    // Applies one request to the local copy of the table and returns the
    // response that the block must give for it.
    function automatic t_rsp table_step(input t_req r);
        logic [SLOT_BITS_MAX-1:0] val;
        logic [SLOT_BITS_MAX-1:0] rd;
        int                       len;
        int                       pos;
        int                       k;
        int                       limit;
        logic                     fits;
        logic                     hit;
        t_rsp                     res;
        len = r.length;
        if (len > MAX_STRING_BYTES_DEF - 1) len = MAX_STRING_BYTES_DEF - 1;
        pos = r.position;
        val = {r.chunk7, r.chunk6, r.chunk5, r.chunk4,
               r.chunk3, r.chunk2, r.chunk1, r.chunk0};
        for (k = len; k < SLOT_BYTES; k++) val[k*8 +: 8] = 8'h00;
        rd = '0;
        res = '0;
        res.status = STAT_OK;
        case (r.opcode)
            OP_GET: begin
                if (pos >= used) res.status = STAT_RANGE;
                else rd = slots[pos];
            end
            OP_SET: begin
                if (pos >= used) begin
                    res.status = STAT_RANGE;
                end else begin
                    if (width_needed(len) > width_code) width_code = width_needed(len);
                    slots[pos] = val;
                end
            end
            OP_INSERT: begin
                if (pos > used) begin
                    res.status = STAT_RANGE;
                end else if (used >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    if (width_needed(len) > width_code) width_code = width_needed(len);
                    for (k = used; k > pos; k--) slots[k] = slots[k-1];
                    slots[pos] = val;
                    used++;
                end
            end
            OP_DELETE: begin
                if (pos >= used) begin
                    res.status = STAT_RANGE;
                end else begin
                    for (k = pos; k + 1 < used; k++) slots[k] = slots[k+1];
                    used--;
                end
            end
            OP_FIND: begin
                limit = width_bytes(width_code);
                fits = (limit == 0) ? (len == 0) : (len < limit);
                res.status = STAT_NOT_FOUND;
                hit = 1'b0;
                if (used != 0 && fits) begin
                    for (k = 0; k < used && !hit; k++) begin
                        if (slots[k] == val) begin
                            hit = 1'b1;
                            res.status = STAT_OK;
                            res.match_index = k[7:0];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        {res.out_chunk7, res.out_chunk6, res.out_chunk5, res.out_chunk4,
         res.out_chunk3, res.out_chunk2, res.out_chunk1, res.out_chunk0} = rd;
        res.entry_total = used[8:0];
        res.width_class = width_code;
        return res;
    endfunction

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        $display("pst_table_checker: %s: got %0h, expected %0h", what, got, want);
        o_errors++;
    endtask

    task automatic compare_rsp(input t_rsp got, input t_rsp want);
        logic [SLOT_BITS_MAX-1:0] got_bytes;
        logic [SLOT_BITS_MAX-1:0] want_bytes;
        got_bytes = {got.out_chunk7, got.out_chunk6, got.out_chunk5, got.out_chunk4,
                     got.out_chunk3, got.out_chunk2, got.out_chunk1, got.out_chunk0};
        want_bytes = {want.out_chunk7, want.out_chunk6, want.out_chunk5, want.out_chunk4,
                      want.out_chunk3, want.out_chunk2, want.out_chunk1, want.out_chunk0};
        for (int i = 0; i < 8; i++) begin
            if (got_bytes[i*64 +: 64] !== want_bytes[i*64 +: 64]) begin
                report($sformatf("out_chunk%0d", i), got_bytes[i*64 +: 64],
                       want_bytes[i*64 +: 64]);
            end
        end
        if (got.match_index !== want.match_index) begin
            report("match_index", got.match_index, want.match_index);
        end
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.entry_total !== want.entry_total) begin
            report("entry_total", got.entry_total, want.entry_total);
        end
        if (got.width_class !== want.width_class) begin
            report("width_class", got.width_class, want.width_class);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            used = 0;
            width_code = 3'd0;
            expected_rsp_q.delete();
        end else begin
            // A response taken at this edge always belongs to an earlier request.
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_rsp_q.size() == 0) begin
                    report("response with no request waiting", i_rsp.data.status, 0);
                end else begin
                    compare_rsp(i_rsp.data, expected_rsp_q.pop_front());
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_rsp_q.push_back(table_step(i_req.data));
            end
        end
        o_waiting <= expected_rsp_q.size();
    end

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// String table testbench
// Drives the padded string table with a short directed sequence and then with
// random requests that fill the table to full, churn it, drain it to empty
// and churn it again, with random stalls on both channels. The checker beside
// the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top;
    import pst_pkg::*;

    localparam int         TABLE_DEPTH    = MAX_ENTRIES_DEF;
    localparam int         RANDOM_ITEMS   = 1400;
    localparam int         CALM_FROM      = 1250;
    localparam int         CYCLE_LIMIT    = 400000;
    localparam int         POOL_SIZE      = 16;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    typedef enum {GROW, CHURN, SHRINK, MIXED} t_phase;

    logic clk = 1'b0;
    logic rst_n;
    int   cycles = 0;
    int   errs;
    int   waiting;
    bit   calm;
    int   rows;
    t_req pool [POOL_SIZE];
    int   pool_used;

    pst_req_if req_ch ();
    pst_rsp_if rsp_ch ();

    padded_string_table DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    pst_table_checker u_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_req     (req_ch),
        .i_rsp     (rsp_ch),
        .o_errors  (errs),
        .o_waiting (waiting)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic t_req mk(input logic [2:0] op, input logic [8:0] pos,
                                input logic [5:0] len, input logic [63:0] pat);
        t_req item;
        item.opcode = op;
        item.position = pos;
        item.length = len;
        item.chunk0 = pat;
        item.chunk1 = pat;
        item.chunk2 = pat;
        item.chunk3 = pat;
        item.chunk4 = pat;
        item.chunk5 = pat;
        item.chunk6 = pat;
        item.chunk7 = pat;
        return item;
    endfunction

    function automatic logic [5:0] pick_length();
        case ($urandom_range(0, 6))
            0: return 6'd0;
            1: return 6'($urandom_range(1, 3));
            2: return 6'($urandom_range(4, 7));
            3: return 6'($urandom_range(8, 15));
            4: return 6'($urandom_range(16, 31));
            5: return 6'($urandom_range(32, 63));
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic t_req make_item(input t_phase ph);
        t_req       item;
        logic [2:0] op;
        int         w;
        w = $urandom_range(0, 99);
        if (ph == GROW) begin
            op = (w < 70) ? OP_INSERT : (w < 78) ? OP_SET : (w < 86) ? OP_GET :
                 (w < 94) ? OP_FIND : (w < 98) ? OP_DELETE : OP_SPARE_FIRST;
        end else if (ph == SHRINK) begin
            op = (w < 70) ? OP_DELETE : (w < 76) ? OP_INSERT : (w < 84) ? OP_SET :
                 (w < 90) ? OP_GET : (w < 98) ? OP_FIND : OP_SPARE_FIRST;
        end else begin
            op = (w < 22) ? OP_INSERT : (w < 44) ? OP_DELETE : (w < 58) ? OP_SET :
                 (w < 76) ? OP_GET : (w < 96) ? OP_FIND : OP_SPARE_FIRST;
        end
        if (op == OP_SPARE_FIRST) op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        if (pool_used > 0 && $urandom_range(0, 9) < 4) begin
            item = pool[$urandom_range(0, pool_used - 1)];
        end else begin
            item = mk(op, 9'd0, pick_length(), '0);
            item.chunk0 = {$urandom, $urandom};
            item.chunk1 = {$urandom, $urandom};
            item.chunk2 = {$urandom, $urandom};
            item.chunk3 = {$urandom, $urandom};
            item.chunk4 = {$urandom, $urandom};
            item.chunk5 = {$urandom, $urandom};
            item.chunk6 = {$urandom, $urandom};
            item.chunk7 = {$urandom, $urandom};
        end
        item.opcode = op;
        if (op == OP_FIND || op >= OP_SPARE_FIRST || $urandom_range(0, 9) == 0) begin
            item.position = 9'($urandom_range(0, 511));
        end else if (op == OP_INSERT) begin
            item.position = 9'($urandom_range(0, rows));
        end else if (rows > 0) begin
            item.position = 9'($urandom_range(0, rows - 1));
        end else begin
            item.position = 9'd0;
        end
        return item;
    endfunction

    task automatic send_item(input t_req item);
        if (!calm && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req_ch.data <= item;
        req_ch.valid <= 1'b1;
        do @(posedge clk); while (!req_ch.ready);
        if (item.opcode == OP_INSERT && item.position <= rows && rows < TABLE_DEPTH) begin
            rows++;
        end
        if (item.opcode == OP_DELETE && item.position < rows) rows--;
        if (item.opcode == OP_INSERT || item.opcode == OP_SET) begin
            if (pool_used < POOL_SIZE) pool[pool_used++] = item;
            else pool[$urandom_range(0, POOL_SIZE - 1)] = item;
        end
    endtask

    initial begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    initial begin
        t_phase ph;
        int     full_hits;
        int     empty_hits;
        int     churn_done;
        int     op_code;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data <= '0;
        calm = 1'b0;
        rows = 0;
        pool_used = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table, unused opcodes, the zero-width search rule, the cannot-fit
        // rule and the longest length, then shifts on a small table.
        send_item(mk(OP_FIND, 9'd0, 6'd0, '0));
        send_item(mk(OP_GET, 9'd0, 6'd0, '1));
        send_item(mk(OP_DELETE, 9'd0, 6'd0, '1));
        send_item(mk(OP_SET, 9'd0, 6'd5, '1));
        send_item(mk(OP_INSERT, 9'd1, 6'd2, '1));
        for (op_code = OP_SPARE_FIRST; op_code <= OP_SPARE_LAST; op_code++) begin
            send_item(mk(op_code[2:0], 9'd511, 6'd63, '1));
        end
        send_item(mk(OP_INSERT, 9'd0, 6'd0, '1));
        send_item(mk(OP_FIND, 9'd300, 6'd0, 64'h5a5a_a5a5_0f0f_f0f0));
        send_item(mk(OP_FIND, 9'd0, 6'd1, '0));
        send_item(mk(OP_INSERT, 9'd1, 6'd3, '1));
        send_item(mk(OP_FIND, 9'd0, 6'd4, '1));
        send_item(mk(OP_FIND, 9'd0, 6'd3, '1));
        send_item(mk(OP_INSERT, 9'd0, 6'd63, '1));
        send_item(mk(OP_GET, 9'd0, 6'd0, '0));
        send_item(mk(OP_GET, 9'd2, 6'd0, '0));
        send_item(mk(OP_SET, 9'd1, 6'd7, 64'h0123_4567_89ab_cdef));
        send_item(mk(OP_GET, 9'd1, 6'd0, '0));
        send_item(mk(OP_DELETE, 9'd1, 6'd0, '0));
        send_item(mk(OP_GET, 9'd2, 6'd0, '0));
        send_item(mk(OP_INSERT, 9'd2, 6'd16, 64'hfedc_ba98_7654_3210));
        send_item(mk(OP_FIND, 9'd0, 6'd63, '0));
        send_item(mk(OP_DELETE, 9'd0, 6'd0, '0));
        send_item(mk(OP_INSERT, 9'd256, 6'd8, '1));

        ph = GROW;
        full_hits = 0;
        empty_hits = 0;
        churn_done = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= CALM_FROM);
            case (ph)
                GROW: begin
                    if (rows == TABLE_DEPTH) full_hits++;
                    if (full_hits > 12) ph = CHURN;
                end
                CHURN: begin
                    churn_done++;
                    if (churn_done >= 250) ph = SHRINK;
                end
                SHRINK: begin
                    if (rows == 0) empty_hits++;
                    if (empty_hits > 8) ph = MIXED;
                end
                default: begin
                end
            endcase
            send_item(make_item(ph));
        end
        req_ch.valid <= 1'b0;

        do @(posedge clk); while (waiting != 0);
        repeat (10) @(posedge clk);
        if (errs == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
